// File: rtl/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
`default_nettype none
package bsa_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = 6;
  localparam int CNT_W      = 7;
  localparam int FUNC_W     = 3;
  localparam int BASE_W     = 32;
  localparam int ESIZE_W    = 16;
  localparam int ADDR_W     = 33;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [FUNC_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_RELEASE = 3'd1,
    OP_MARK    = 3'd2,
    OP_SWEEP   = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 1'd0,
    REG_ELEMENT_SIZE = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              alloc_failed;
    logic              slot_busy;
    logic [CNT_W-1:0]  swept_count;
    logic [CNT_W-1:0]  used_count;
    logic              is_full;
  } op_res_t;

endpackage
`default_nettype wire

// File: rtl/bitmap_slot_allocator_sweep.sv
// A word passes the input stage, the result stage and the output register in turn.
// Throughput: one word per cycle while the output is not stalled; the bitmap
// update for a word is made as it leaves the input stage, so the next word sees the new state.
// All stages advance together whenever the output register is empty or taken.
// Synchronous active-low reset frees every slot, clears all marks, sets the
// base address to 0 and the element size to 1, and empties the pipeline.
`default_nettype none
module bitmap_slot_allocator_sweep (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [2:0] func, [8:3] slot, [15:9] zero
  input  wire logic [bsa_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [5:0] slot_index, [38:6] slot_address, [39] alloc_failed, [40] slot_busy,
  // [47:41] swept_count, [54:48] used_count, [55] is_full
  output logic [bsa_pkg::OUT_DATA_W-1:0]       out_tdata
);

  logic [bsa_pkg::BASE_W-1:0]  base_r;
  logic [bsa_pkg::ESIZE_W-1:0] esize_r;

  logic                        advance;
  logic                        s1_valid_r, s2_valid_r, out_valid_r;
  logic [bsa_pkg::FUNC_W-1:0]  s1_func_r;
  logic [bsa_pkg::SLOT_W-1:0]  s1_slot_r;
  bsa_pkg::op_res_t            core_res, s2_res_r, out_res_r;
  logic [bsa_pkg::SLOT_W+bsa_pkg::ESIZE_W-1:0] addr_prod;
  logic [bsa_pkg::ADDR_W-1:0]  addr_nxt, out_addr_r;

  assign cfg_ready  = 1'b1;
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = advance;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      esize_r <= bsa_pkg::ESIZE_W'(1);
    end else if (cfg_valid) begin
      case (bsa_pkg::reg_idx_t'(cfg_index))
        bsa_pkg::REG_BASE_ADDRESS: base_r  <= cfg_data[bsa_pkg::BASE_W-1:0];
        bsa_pkg::REG_ELEMENT_SIZE: esize_r <= cfg_data[bsa_pkg::ESIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bsa_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance && s1_valid_r),
    .func  (s1_func_r),
    .slot  (s1_slot_r),
    .res   (core_res)
  );

  // The address is formed one stage after the bitmap search.
  always_comb begin
    addr_prod = {{bsa_pkg::ESIZE_W{1'b0}}, s2_res_r.slot_index}
              * {{bsa_pkg::SLOT_W{1'b0}}, esize_r};
    if (s2_res_r.alloc_failed) begin
      addr_nxt = '0;
    end else begin
      addr_nxt = bsa_pkg::ADDR_W'(base_r) + bsa_pkg::ADDR_W'(addr_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_tvalid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_func_r  <= in_tdata[2:0];
      s1_slot_r  <= in_tdata[8:3];
      s2_res_r   <= core_res;
      out_res_r  <= s2_res_r;
      out_addr_r <= addr_nxt;
    end
  end

  assign out_tdata = {out_res_r.is_full, out_res_r.used_count, out_res_r.swept_count,
                      out_res_r.slot_busy, out_res_r.alloc_failed, out_addr_r,
                      out_res_r.slot_index};

endmodule
`default_nettype wire

// File: rtl/bsa_core.sv
// Bitmap state and the per-word allocate, release, mark, sweep and query logic.
`default_nettype none
module bsa_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic [bsa_pkg::FUNC_W-1:0]  func,
  input  wire logic [bsa_pkg::SLOT_W-1:0]  slot,
  output bsa_pkg::op_res_t                 res
);

  localparam int N      = bsa_pkg::SLOT_COUNT;
  localparam int GROUPS = (N + 7) / 8;

  logic [N-1:0]              occ_r, occ_nxt;
  logic [N-1:0]              mark_r, mark_nxt;
  logic [bsa_pkg::CNT_W-1:0] used_r, used_nxt;

  logic [N-1:0]              free_bits, low_bit, slot_bit, dead;
  logic                      found, busy;
  logic [bsa_pkg::SLOT_W-1:0] low_idx;
  logic [bsa_pkg::CNT_W-1:0] swept;
  logic [3:0]                grp_cnt [GROUPS];

  always_comb begin
    free_bits = ~occ_r;
    found     = |free_bits;
    // Isolate the lowest free slot, then encode the one-hot position.
    low_bit   = free_bits & (~free_bits + {{(N-1){1'b0}}, 1'b1});
    low_idx   = '0;
    for (int i = 0; i < N; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | bsa_pkg::SLOT_W'(i);
      end
    end
    slot_bit = {{(N-1){1'b0}}, 1'b1} << slot;
    busy     = |(occ_r & slot_bit);
    dead     = occ_r & ~mark_r;
    // Population count in byte groups, then a sum of the group counts.
    for (int g = 0; g < GROUPS; g++) begin
      grp_cnt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (g * 8 + b < N) begin
          grp_cnt[g] = grp_cnt[g] + 4'(dead[g*8+b]);
        end
      end
    end
    swept = '0;
    for (int g = 0; g < GROUPS; g++) begin
      swept = swept + bsa_pkg::CNT_W'(grp_cnt[g]);
    end
  end

  always_comb begin
    occ_nxt          = occ_r;
    mark_nxt         = mark_r;
    used_nxt         = used_r;
    res.slot_index   = slot;
    res.alloc_failed = 1'b0;
    res.slot_busy    = busy;
    res.swept_count  = '0;
    case (bsa_pkg::op_t'(func))
      bsa_pkg::OP_ALLOC: begin
        res.slot_busy = 1'b0;
        if (found) begin
          res.slot_index = low_idx;
          occ_nxt        = occ_r | low_bit;
          mark_nxt       = mark_r & ~low_bit;
          used_nxt       = used_r + bsa_pkg::CNT_W'(1);
        end else begin
          res.slot_index   = '0;
          res.alloc_failed = 1'b1;
        end
      end
      bsa_pkg::OP_RELEASE: begin
        occ_nxt  = occ_r & ~slot_bit;
        mark_nxt = mark_r & ~slot_bit;
        used_nxt = used_r - bsa_pkg::CNT_W'(busy);
      end
      bsa_pkg::OP_MARK: begin
        mark_nxt = mark_r | (slot_bit & occ_r);
      end
      bsa_pkg::OP_SWEEP: begin
        occ_nxt         = occ_r & ~dead;
        mark_nxt        = '0;
        used_nxt        = used_r - swept;
        res.swept_count = swept;
      end
      default: begin
      end
    endcase
    res.used_count = used_nxt;
    res.is_full    = (used_nxt == bsa_pkg::CNT_W'(N));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= '0;
      mark_r <= '0;
      used_r <= '0;
    end else if (en) begin
      occ_r  <= occ_nxt;
      mark_r <= mark_nxt;
      used_r <= used_nxt;
    end
  end

endmodule
`default_nettype wire
